/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the chunk stream parser.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, skipped while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on the rising clock, also during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/scsp_pkg.sv */
// Package for the settings chunk stream parser: widths, reset signatures,
// chunk geometry and status codes. No dependencies.
package scsp_pkg;

  localparam int unsigned SigWidth  = 16;
  localparam int unsigned KeyWidth  = 16;
  localparam int unsigned ValWidth  = 64;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned IdxWidth  = 4;

  localparam logic [SigWidth-1:0] SettingsSigReset = 16'h505A;  // "PZ"
  localparam logic [SigWidth-1:0] DataSigReset     = 16'h5058;  // "PX"

  localparam logic [IdxWidth-1:0] HdrLastIdx = 4'd11;  // 12-byte header
  localparam logic [IdxWidth-1:0] RecLastIdx = 4'd9;   // 10-byte record
  localparam logic [IdxWidth-1:0] SumFirstIdx = 4'd4;
  localparam logic [IdxWidth-1:0] ValFirstIdx = 4'd2;

  // Configuration register indexes
  localparam logic CfgSettingsSig = 1'b0;
  localparam logic CfgDataSig     = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_BADSIG = 3'd2,
    ST_TRUNC  = 3'd3,
    ST_SUM    = 3'd4
  } status_t;

endpackage

/* src/settings_chunk_stream_parser_top.sv */
// Settings chunk stream parser, top level.
// Depends on scsp_pkg and assert_macros.svh.
//
// Usage:
//   Bytes of a settings image enter on data_byte/final_byte with the
//   byte_valid/byte_ready handshake; final_byte marks the last byte.
//   Each chunk is a 12-byte header (signature, record count, XOR checksum)
//   followed by 10-byte records. A result transaction leaves on
//   result_valid/result_ready carrying a finished record, an end of image
//   with status, or both.
//   Throughput: one byte per cycle while byte_ready is high. Each accepted
//   byte updates the parse state in the same cycle; its result, if any, is
//   written to the result register in that same cycle.
//   When the receiver stalls, byte_ready stays high while the result
//   register is empty or being drained; a held result stops intake.
//   Synchronous reset clears the parse state, empties the result register
//   and restores both signature registers to "PZ" and "PX". The user
//   must write signatures via cfg_write/cfg_index/cfg_data while idle;
//   not enforced. After an error, bytes are dropped until the final byte.
`include "assert_macros.svh"

module settings_chunk_stream_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [scsp_pkg::SigWidth-1:0]   cfg_data,
  // byte input channel
  input  logic                            byte_valid,
  output logic                            byte_ready,
  input  logic [7:0]                      data_byte,
  input  logic                            final_byte,
  // result channel
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            record_valid,
  output logic                            record_store,
  output logic [scsp_pkg::KeyWidth-1:0]   record_key,
  output logic [scsp_pkg::ValWidth-1:0]   record_value,
  output logic                            image_done,
  output logic [2:0]                      image_status
);
  import scsp_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DROP   = 2'd2
  } phase_t;

  // Configuration registers
  logic [SigWidth-1:0] settings_sig;
  logic [SigWidth-1:0] data_sig;

  // Parse state
  phase_t                phase, phase_next;
  logic [IdxWidth-1:0]   byte_index, byte_index_next;
  logic [7:0]            first_sig_byte, first_sig_byte_next;
  logic                  chunk_store, chunk_store_next;
  logic                  sig_match, sig_match_next;
  logic [CountWidth-1:0] expected_count, expected_count_next;
  logic [CountWidth-1:0] records_seen, records_seen_next;
  logic [ValWidth-1:0]   expected_sum, expected_sum_next;
  logic [ValWidth-1:0]   running_sum, running_sum_next;
  logic [KeyWidth-1:0]   key_shift, key_shift_next;
  logic [ValWidth-1:0]   value_shift, value_shift_next;

  // Result of the byte being accepted
  logic                  rec, done, rearm;
  status_t               status;
  logic [KeyWidth-1:0]   rec_key;
  logic [ValWidth-1:0]   rec_value;
  logic [SigWidth-1:0]   sig;
  logic [2:0]            sum_lane;
  logic [2:0]            val_lane;

  // Result register
  logic                  res_rec;
  logic                  res_store;
  logic [KeyWidth-1:0]   res_key;
  logic [ValWidth-1:0]   res_value;
  logic                  res_done;
  status_t               res_status;

  logic accept;

  assign byte_ready = !result_valid || result_ready;
  assign accept     = byte_valid && byte_ready;

  assign sig      = {first_sig_byte, data_byte};
  assign sum_lane = 3'(byte_index - SumFirstIdx);
  assign val_lane = 3'(byte_index - ValFirstIdx);

  // Next parse state for the byte on the input
  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    first_sig_byte_next = first_sig_byte;
    chunk_store_next    = chunk_store;
    sig_match_next      = sig_match;
    expected_count_next = expected_count;
    records_seen_next   = records_seen;
    expected_sum_next   = expected_sum;
    running_sum_next    = running_sum;
    key_shift_next      = key_shift;
    value_shift_next    = value_shift;
    rec       = 1'b0;
    done      = 1'b0;
    rearm     = 1'b0;
    status    = ST_OK;
    rec_key   = '0;
    rec_value = '0;

    case (phase)
      PH_HEADER: begin
        // collect header fields
        case (byte_index)
          4'd0: first_sig_byte_next = data_byte;
          4'd1: begin
            if (sig == settings_sig) begin
              chunk_store_next = 1'b0;
              sig_match_next   = 1'b1;
            end else if (sig == data_sig) begin
              chunk_store_next = 1'b1;
              sig_match_next   = 1'b1;
            end else begin
              chunk_store_next = 1'b0;
              sig_match_next   = 1'b0;
            end
          end
          4'd2: expected_count_next = {8'h00, data_byte};
          4'd3: expected_count_next = {data_byte, expected_count[7:0]};
          default: begin
            if (byte_index <= HdrLastIdx) begin
              expected_sum_next[{sum_lane, 3'b000} +: 8] = data_byte;
            end
          end
        endcase

        if (byte_index < HdrLastIdx) begin
          byte_index_next = byte_index + 4'd1;
          if (final_byte) begin
            done   = 1'b1;
            status = ST_SHORT;
            rearm  = 1'b1;
          end
        end else if (!sig_match) begin
          done   = 1'b1;
          status = ST_BADSIG;
          if (final_byte) rearm = 1'b1;
          else phase_next = PH_DROP;
        end else begin
          running_sum_next  = '0;
          records_seen_next = '0;
          byte_index_next   = '0;
          key_shift_next    = '0;
          value_shift_next  = '0;
          if (expected_count_next == '0) begin
            // empty chunk: checksum must be zero
            if (expected_sum_next != '0) begin
              done   = 1'b1;
              status = ST_SUM;
              if (final_byte) rearm = 1'b1;
              else phase_next = PH_DROP;
            end else begin
              done  = final_byte;
              rearm = 1'b1;
            end
          end else if (final_byte) begin
            done   = 1'b1;
            status = ST_TRUNC;
            rearm  = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end
      end

      PH_BODY: begin
        // assemble the record
        if (byte_index < ValFirstIdx) begin
          key_shift_next[{byte_index[0], 3'b000} +: 8] = data_byte;
        end else if (byte_index <= RecLastIdx) begin
          value_shift_next[{val_lane, 3'b000} +: 8] = data_byte;
        end

        if (byte_index >= RecLastIdx) begin
          rec               = 1'b1;
          rec_key           = key_shift_next;
          rec_value         = value_shift_next;
          running_sum_next  = running_sum ^ value_shift_next;
          records_seen_next = records_seen + 16'd1;
          byte_index_next   = '0;
          key_shift_next    = '0;
          value_shift_next  = '0;
          if (records_seen_next == expected_count) begin
            // last record of the chunk: compare checksums
            if (running_sum_next != expected_sum) begin
              done   = 1'b1;
              status = ST_SUM;
              if (final_byte) rearm = 1'b1;
              else phase_next = PH_DROP;
            end else begin
              done  = final_byte;
              rearm = 1'b1;
            end
          end else if (final_byte) begin
            done   = 1'b1;
            status = ST_TRUNC;
            rearm  = 1'b1;
          end
        end else begin
          byte_index_next = byte_index + 4'd1;
          if (final_byte) begin
            done   = 1'b1;
            status = ST_TRUNC;
            rearm  = 1'b1;
          end
        end
      end

      default: begin
        // drop bytes until the image ends
        if (final_byte) rearm = 1'b1;
      end
    endcase

    // rearm for a new chunk or image
    if (rearm) begin
      phase_next          = PH_HEADER;
      byte_index_next     = '0;
      first_sig_byte_next = '0;
      chunk_store_next    = 1'b0;
      sig_match_next      = 1'b0;
      expected_count_next = '0;
      records_seen_next   = '0;
      expected_sum_next   = '0;
      running_sum_next    = '0;
      key_shift_next      = '0;
      value_shift_next    = '0;
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      settings_sig <= SettingsSigReset;
      data_sig     <= DataSigReset;
    end else if (cfg_write) begin
      case (cfg_index)
        CfgSettingsSig: settings_sig <= cfg_data;
        CfgDataSig:     data_sig     <= cfg_data;
        default:        settings_sig <= settings_sig;
      endcase
    end
  end

  // Advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_index     <= '0;
      first_sig_byte <= '0;
      chunk_store    <= 1'b0;
      sig_match      <= 1'b0;
      expected_count <= '0;
      records_seen   <= '0;
      expected_sum   <= '0;
      running_sum    <= '0;
      key_shift      <= '0;
      value_shift    <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      first_sig_byte <= first_sig_byte_next;
      chunk_store    <= chunk_store_next;
      sig_match      <= sig_match_next;
      expected_count <= expected_count_next;
      records_seen   <= records_seen_next;
      expected_sum   <= expected_sum_next;
      running_sum    <= running_sum_next;
      key_shift      <= key_shift_next;
      value_shift    <= value_shift_next;
    end
  end

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= rec || done;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_rec    <= rec;
      res_store  <= rec && chunk_store;
      res_key    <= rec_key;
      res_value  <= rec_value;
      res_done   <= done;
      res_status <= status;
    end
  end

  assign record_valid = res_rec;
  assign record_store = res_store;
  assign record_key   = res_key;
  assign record_value = res_value;
  assign image_done   = res_done;
  assign image_status = res_status;

  // Checks
  `CHK_ASSERT(a_result_nonempty, clk, rst, result_valid |-> (record_valid || image_done), "result transaction carries neither record nor end of image")
  `CHK_ASSERT(a_body_index, clk, rst, (phase == PH_BODY) |-> (byte_index <= RecLastIdx), "record byte index out of range")
  `CHK_ASSERT(a_header_index, clk, rst, (phase == PH_HEADER) |-> (byte_index <= HdrLastIdx), "header byte index out of range")
  `CHK_ASSERT(a_final_rearms, clk, rst, (accept && final_byte) |=> (phase == PH_HEADER && byte_index == '0), "parser not rearmed after final byte")

endmodule

/* bench/tb_settings_chunk_stream_parser_top.sv */
// Testbench for settings_chunk_stream_parser_top: drives whole and broken settings images
// byte by byte and checks each result transaction against an in-bench parse model.
// Depends on scsp_pkg and the top-level RTL.
module tb_settings_chunk_stream_parser_top;
  import scsp_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int CALM_ITEMS = 120;
  localparam int BYTES_PER_PHASE = 150;
  localparam int NUM_PHASES = 6;
  localparam int TAIL_CYCLES = 8;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef enum logic [1:0] {PARSE_HEADER, PARSE_BODY, PARSE_DROP} parse_phase_t;
  typedef enum logic [1:0] {ITEM_BYTE, ITEM_CFG, ITEM_DRAIN} item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [7:0]          data;
    logic                last;
    logic                cfg_sel;
    logic [SigWidth-1:0] cfg_val;
  } stim_item_t;

  typedef struct packed {
    logic                rec;
    logic                store;
    logic [KeyWidth-1:0] key;
    logic [ValWidth-1:0] value;
    logic                done;
    status_t             status;
  } parse_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic                cfg_index = 1'b0;
  logic [SigWidth-1:0] cfg_data = '0;
  logic                byte_valid = 1'b0;
  logic                byte_ready;
  logic [7:0]          data_byte = '0;
  logic                final_byte = 1'b0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic                record_valid;
  logic                record_store;
  logic [KeyWidth-1:0] record_key;
  logic [ValWidth-1:0] record_value;
  logic                image_done;
  logic [2:0]          image_status;

  settings_chunk_stream_parser_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .data_byte    (data_byte),
    .final_byte   (final_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .record_valid (record_valid),
    .record_store (record_store),
    .record_key   (record_key),
    .record_value (record_value),
    .image_done   (image_done),
    .image_status (image_status)
  );

  initial forever #(CLK_PERIOD / 2) clk = ~clk;

  // Pending stimulus and the results the parse model expects
  stim_item_t    pending_items[$];
  parse_result_t expected_results[$];
  int            outstanding = 0;
  int            errors = 0;

  // Parse model state
  logic [SigWidth-1:0]   model_settings_sig;
  logic [SigWidth-1:0]   model_data_sig;
  parse_phase_t          model_phase;
  logic [IdxWidth-1:0]   model_idx;
  logic [7:0]            model_sig_hi;
  logic                  model_store;
  logic                  model_sig_ok;
  logic [CountWidth-1:0] model_count;
  logic [CountWidth-1:0] model_seen;
  logic [ValWidth-1:0]   model_sum_want;
  logic [ValWidth-1:0]   model_sum_run;
  logic [KeyWidth-1:0]   model_key;
  logic [ValWidth-1:0]   model_value;

  // Return the parse model to the start of a new image
  task automatic parse_rearm();
    model_phase = PARSE_HEADER;
    model_idx = '0;
    model_sig_hi = '0;
    model_store = 1'b0;
    model_sig_ok = 1'b0;
    model_count = '0;
    model_seen = '0;
    model_sum_want = '0;
    model_sum_run = '0;
    model_key = '0;
    model_value = '0;
  endtask

  // Close a chunk: judge the checksum, then end the image, await the next header or drop to the image end
  task automatic close_chunk(input logic last, output logic done, output status_t st);
    done = 1'b0;
    st = ST_OK;
    if (model_sum_run != model_sum_want) begin
      done = 1'b1;
      st = ST_SUM;
      if (last) parse_rearm();
      else model_phase = PARSE_DROP;
    end else begin
      done = last;
      parse_rearm();
    end
  endtask

  // Advance the parse model by one byte and build the result it causes, if any
  task automatic parse_byte(input logic [7:0] b, input logic last, output logic emitted,
                            output parse_result_t res);
    logic [SigWidth-1:0] sig;
    logic [IdxWidth-1:0] i;
    logic                done_flag;
    status_t             st;
    res = '0;
    i = model_idx;
    case (model_phase)
      PARSE_HEADER: begin
        if (i == 0) begin
          model_sig_hi = b;
        end else if (i == 1) begin
          sig = {model_sig_hi, b};
          if (sig == model_settings_sig) begin
            model_store = 1'b0;
            model_sig_ok = 1'b1;
          end else if (sig == model_data_sig) begin
            model_store = 1'b1;
            model_sig_ok = 1'b1;
          end else begin
            model_store = 1'b0;
            model_sig_ok = 1'b0;
          end
        end else if (i == 2) begin
          model_count = {8'h00, b};
        end else if (i == 3) begin
          model_count[15:8] = b;
        end else begin
          model_sum_want[8 * (i - SumFirstIdx) +: 8] = b;
        end
        if (i < HdrLastIdx) begin
          model_idx = i + 1'b1;
          if (last) begin
            res.done = 1'b1;
            res.status = ST_SHORT;
            parse_rearm();
          end
        end else if (!model_sig_ok) begin
          res.done = 1'b1;
          res.status = ST_BADSIG;
          if (last) parse_rearm();
          else model_phase = PARSE_DROP;
        end else begin
          model_sum_run = '0;
          model_seen = '0;
          model_idx = '0;
          model_key = '0;
          model_value = '0;
          if (model_count == 0) begin
            close_chunk(last, done_flag, st);
            res.done = done_flag;
            res.status = st;
          end else if (last) begin
            res.done = 1'b1;
            res.status = ST_TRUNC;
            parse_rearm();
          end else begin
            model_phase = PARSE_BODY;
          end
        end
      end
      PARSE_BODY: begin
        if (i < ValFirstIdx) model_key[8 * i +: 8] = b;
        else model_value[8 * (i - ValFirstIdx) +: 8] = b;
        if (i >= RecLastIdx) begin
          res.rec = 1'b1;
          res.store = model_store;
          res.key = model_key;
          res.value = model_value;
          model_sum_run ^= model_value;
          model_seen = model_seen + 1'b1;
          model_idx = '0;
          model_key = '0;
          model_value = '0;
          if (model_seen == model_count) begin
            close_chunk(last, done_flag, st);
            res.done = done_flag;
            res.status = st;
          end else if (last) begin
            res.done = 1'b1;
            res.status = ST_TRUNC;
            parse_rearm();
          end
        end else begin
          model_idx = i + 1'b1;
          if (last) begin
            res.done = 1'b1;
            res.status = ST_TRUNC;
            parse_rearm();
          end
        end
      end
      default: begin
        if (last) parse_rearm();
      end
    endcase
    emitted = res.rec | res.done;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // Monitor: check result transactions, track register writes, predict accepted bytes
  always @(posedge clk) begin : result_monitor
    parse_result_t want;
    logic          emitted;
    if (rst) begin
      expected_results.delete();
      model_settings_sig = SettingsSigReset;
      model_data_sig = DataSigReset;
      parse_rearm();
      outstanding <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: record_valid %0b, image_done %0b, image_status %0d",
                 record_valid, image_done, image_status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("record_valid", want.rec, record_valid);
          check_field("record_store", want.store, record_store);
          check_field("record_key", want.key, record_key);
          check_field("record_value", want.value, record_value);
          check_field("image_done", want.done, image_done);
          check_field("image_status", want.status, image_status);
        end
      end
      if (cfg_write) begin
        if (cfg_index == CfgSettingsSig) model_settings_sig = cfg_data;
        else model_data_sig = cfg_data;
      end
      if (byte_valid && byte_ready) begin
        parse_byte(data_byte, final_byte, emitted, want);
        if (emitted) expected_results.insert(expected_results.size(), want);
      end
      outstanding <= expected_results.size();
    end
  end

  // Driver state
  int  send_gap;
  int  stall_gap;
  int  settle_cnt;
  bit  quiet;

  // Driver: feed bytes and register writes, idle and stall in random bursts
  always @(posedge clk) begin : stim_driver
    stim_item_t item;
    logic       valid_next;
    logic       write_next;
    logic       busy;
    valid_next = 1'b0;
    write_next = 1'b0;
    if (rst) begin
      send_gap = 0;
      stall_gap = 0;
      settle_cnt = 0;
      quiet = 1'b0;
      result_ready <= 1'b0;
    end else begin
      busy = !quiet && pending_items.size() >= CALM_ITEMS;
      // Receiver side
      if (stall_gap > 0) begin
        stall_gap--;
        result_ready <= 1'b0;
      end else if (busy && $urandom_range(0, 7) == 0) begin
        stall_gap = $urandom_range(0, 4);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
      // Sender side: hold an unaccepted byte, otherwise take the next item
      if (byte_valid && !byte_ready) begin
        valid_next = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (pending_items.size() != 0) begin
        if (pending_items[0].kind == ITEM_BYTE) begin
          item = pending_items.pop_front();
          data_byte <= item.data;
          final_byte <= item.last;
          valid_next = 1'b1;
          settle_cnt = 0;
          if ($urandom_range(0, 99) == 0) quiet = !quiet;
          if (busy && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          // Wait until the parser has gone quiet before a write or a resume
          if (byte_valid || cfg_write || result_valid || outstanding != 0) settle_cnt = 0;
          else settle_cnt++;
          if (settle_cnt >= SETTLE_CYCLES) begin
            item = pending_items.pop_front();
            settle_cnt = 0;
            if (item.kind == ITEM_CFG) begin
              write_next = 1'b1;
              cfg_index <= item.cfg_sel;
              cfg_data <= item.cfg_val;
            end
          end
        end
      end
    end
    byte_valid <= valid_next;
    cfg_write <= write_next;
  end

  // Image generation
  logic [7:0]          image_bytes[$];
  logic [SigWidth-1:0] gen_settings_sig = SettingsSigReset;
  logic [SigWidth-1:0] gen_data_sig = DataSigReset;
  int                  gen_bytes = 0;

  task automatic push_byte(input logic [7:0] b, input logic last);
    stim_item_t item;
    item = '{kind: ITEM_BYTE, data: b, last: last, cfg_sel: 1'b0, cfg_val: '0};
    pending_items.insert(pending_items.size(), item);
    gen_bytes++;
  endtask

  task automatic push_cfg(input logic sel, input logic [SigWidth-1:0] val);
    stim_item_t item;
    item = '{kind: ITEM_CFG, data: 8'h00, last: 1'b0, cfg_sel: sel, cfg_val: val};
    pending_items.insert(pending_items.size(), item);
    if (sel == CfgSettingsSig) gen_settings_sig = val;
    else gen_data_sig = val;
  endtask

  function automatic logic [ValWidth-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [KeyWidth-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return KeyWidth'($urandom());
    endcase
  endfunction

  // Stage one chunk: header with the given count, then nrec records
  task automatic stage_chunk(input logic [SigWidth-1:0] sig, input int unsigned count,
                             input int unsigned nrec, input bit bad_sum);
    logic [7:0]            body[$];
    logic [ValWidth-1:0]   sum;
    logic [ValWidth-1:0]   val;
    logic [KeyWidth-1:0]   key;
    logic [CountWidth-1:0] cnt;
    sum = '0;
    cnt = count[CountWidth-1:0];
    for (int r = 0; r < nrec; r++) begin
      key = pick_key();
      val = pick_value();
      sum ^= val;
      body.insert(body.size(), key[7:0]);
      body.insert(body.size(), key[15:8]);
      for (int k = 0; k < 8; k++) body.insert(body.size(), val[8 * k +: 8]);
    end
    if (bad_sum) sum[$urandom_range(0, ValWidth - 1)] ^= 1'b1;
    image_bytes.insert(image_bytes.size(), sig[15:8]);
    image_bytes.insert(image_bytes.size(), sig[7:0]);
    image_bytes.insert(image_bytes.size(), cnt[7:0]);
    image_bytes.insert(image_bytes.size(), cnt[15:8]);
    for (int k = 0; k < 8; k++) image_bytes.insert(image_bytes.size(), sum[8 * k +: 8]);
    foreach (body[k]) image_bytes.insert(image_bytes.size(), body[k]);
  endtask

  // Send the staged image, cut to its first keep bytes when 0 < keep < size; mark the last byte
  task automatic send_image(input int keep);
    int n;
    n = image_bytes.size();
    if (keep > 0 && keep < n) n = keep;
    for (int k = 0; k < n; k++) push_byte(image_bytes[k], k == n - 1);
    image_bytes.delete();
  endtask

  task automatic random_image();
    int unsigned chunks;
    int unsigned nrec;
    int unsigned count;
    int          keep;
    logic [SigWidth-1:0] sig;
    if ($urandom_range(0, 9) == 0) begin
      // Noise image
      repeat ($urandom_range(1, 16)) image_bytes.insert(image_bytes.size(), 8'($urandom()));
      send_image(0);
    end else begin
      chunks = $urandom_range(1, 3);
      for (int c = 0; c < chunks; c++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: sig = gen_settings_sig;
          19: sig = SigWidth'($urandom());
          default: sig = gen_data_sig;
        endcase
        nrec = $urandom_range(0, 3);
        count = nrec;
        // Occasionally claim more records than the image holds
        if (c == chunks - 1 && $urandom_range(0, 19) == 0)
          count = $urandom_range(nrec + 1, 65535);
        stage_chunk(sig, count, nrec, $urandom_range(0, 11) == 0);
      end
      case ($urandom_range(0, 7))
        0: keep = $urandom_range(1, image_bytes.size());
        1: keep = $urandom_range(1, 12);
        default: keep = 0;
      endcase
      send_image(keep);
    end
  endtask

  initial begin : stim_main
    int         start;
    stim_item_t drain_item;
    // Directed images under the reset signatures
    stage_chunk(gen_settings_sig, 1, 1, 0);
    send_image(5);
    image_bytes.insert(image_bytes.size(), 8'hA5);
    send_image(0);
    stage_chunk(16'h0000, 0, 0, 0);
    send_image(0);
    stage_chunk(16'hFFFF, 2, 2, 0);
    send_image(0);
    stage_chunk(gen_settings_sig, 0, 0, 0);
    stage_chunk(gen_data_sig, 1, 1, 0);
    send_image(0);
    stage_chunk(gen_data_sig, 0, 0, 1);
    send_image(0);
    stage_chunk(gen_settings_sig, 2, 2, 1);
    stage_chunk(gen_data_sig, 1, 1, 0);
    send_image(0);
    stage_chunk(gen_settings_sig, 16'hFFFF, 0, 0);
    send_image(0);
    stage_chunk(gen_data_sig, 3, 3, 0);
    send_image(27);
    stage_chunk(gen_settings_sig, 2, 2, 0);
    send_image(22);

    // Random images over several signature settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: begin
          push_cfg(CfgSettingsSig, 16'h0000);
          push_cfg(CfgDataSig, 16'hFFFF);
        end
        2: begin
          push_cfg(CfgSettingsSig, 16'hFFFF);
          push_cfg(CfgDataSig, 16'h0000);
        end
        3: begin
          // Both signatures equal: the settings match wins, so record_store stays low
          push_cfg(CfgSettingsSig, SigWidth'($urandom()));
          push_cfg(CfgDataSig, gen_settings_sig);
        end
        4: begin
          push_cfg(CfgSettingsSig, SigWidth'($urandom()));
          push_cfg(CfgDataSig, SigWidth'($urandom()));
        end
        5: begin
          push_cfg(CfgSettingsSig, SettingsSigReset);
          push_cfg(CfgDataSig, DataSigReset);
        end
        default: ;
      endcase
      start = gen_bytes;
      while (gen_bytes - start < BYTES_PER_PHASE) begin
        random_image();
        // Let everything drain in the middle of the run, after any image ending in that window
        if (ph == 2 && gen_bytes - start >= BYTES_PER_PHASE / 2 &&
            gen_bytes - start < BYTES_PER_PHASE / 2 + 40 &&
            pending_items[$].kind == ITEM_BYTE) begin
          drain_item = '{kind: ITEM_DRAIN, data: 8'h00, last: 1'b0,
                         cfg_sel: 1'b0, cfg_val: '0};
          pending_items.insert(pending_items.size(), drain_item);
        end
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Wait for every byte to go in and every result to come out
    while (pending_items.size() != 0 || byte_valid || outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
